// ----- rtl/cfd_pkg.sv -----
package cfd_pkg;

   localparam int unsigned MAX_MSG = 1024;
   localparam int unsigned COUNT_W = $clog2(MAX_MSG + 2);
   localparam int unsigned LEN_W = 11;

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [7:0] byte_type;

   typedef enum logic [1:0] {
      KIND_BUS_ID = 2'd0,
      KIND_MESSAGE = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_COBS = 2'd1,
      STATUS_CHECKSUM = 2'd2,
      STATUS_TOO_LONG = 2'd3
   } status_type;

   localparam byte_type SUM_INIT = 8'hFF;
   localparam byte_type CODE_NO_ZERO = 8'hFF;

   typedef struct packed {
      byte_type sum_low;
      byte_type sum_high;
   } sums_type;

   // Ones'-complement add with end-around carry.
   function automatic byte_type oc_add(input byte_type a, input byte_type b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[7:0] + {7'd0, s[8]};
   endfunction

endpackage

// ----- rtl/cobs_fletcher_frame_decoder.sv -----
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | req_link_byte
// rsp     | out       | rsp_valid/rsp_stall | rsp_out_byte, rsp_out_kind,
//         |           |                    | rsp_frame_status, rsp_msg_length
//
// One link byte is taken every unstalled cycle; each byte updates the decoder
// state in the same cycle and its result, if any, lands in the single output
// register. A new byte is taken while the held result is being read out the same
// cycle. The request side stalls only while a held result is stalled downstream.
// Reset is synchronous and returns the decoder to the between-frames state.
module cobs_fletcher_frame_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cfd_pkg::byte_type req_link_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfd_pkg::byte_type rsp_out_byte,
   output logic [1:0]        rsp_out_kind,
   output logic [1:0]        rsp_frame_status,
   output logic [10:0]       rsp_msg_length
);
   import cfd_pkg::*;

   logic      in_frame_ff, in_frame_in;
   byte_type  group_left_ff, group_left_in;
   logic      zero_pending_ff, zero_pending_in;
   byte_type  hold_ff [2];
   byte_type  hold_in [2];
   logic [1:0] hold_count_ff, hold_count_in;
   sums_type  sums_ff, sums_in, sums_next;
   count_type count_ff, count_in;
   logic      too_long_ff, too_long_in;

   logic       rsp_valid_ff;
   byte_type   rsp_byte_ff;
   kind_type   rsp_kind_ff;
   status_type rsp_status_ff;
   logic [LEN_W-1:0] rsp_length_ff;

   logic       accept;
   logic       push_en;
   byte_type   push_data;
   logic       emit_ok;
   logic       res_valid;
   byte_type   res_byte;
   kind_type   res_kind;
   status_type res_status;
   count_type  msg_count;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;

   cfd_fletcher u_fletcher (
      .sums      (sums_ff),
      .data      (hold_ff[0]),
      .sums_next (sums_next)
   );

   always_comb begin
      in_frame_in = in_frame_ff;
      group_left_in = group_left_ff;
      zero_pending_in = zero_pending_ff;
      hold_in = hold_ff;
      hold_count_in = hold_count_ff;
      sums_in = sums_ff;
      count_in = count_ff;
      too_long_in = too_long_ff;
      push_en = 1'b0;
      push_data = req_link_byte;
      emit_ok = 1'b0;
      res_valid = 1'b0;
      res_byte = req_link_byte;
      res_kind = KIND_STATUS;
      res_status = STATUS_OK;
      msg_count = (count_ff != '0) ? count_ff - count_type'(1) : '0;

      if (req_link_byte == 8'd0) begin
         // Delimiter: report the frame in progress, then start clean.
         res_valid = in_frame_ff;
         res_byte = 8'd0;
         if (group_left_ff != 8'd0 || hold_count_ff != 2'd2 || count_ff == '0) begin
            res_status = STATUS_COBS;
         end else if (too_long_ff) begin
            res_status = STATUS_TOO_LONG;
         end else if (hold_ff[0] != sums_ff.sum_low || hold_ff[1] != sums_ff.sum_high) begin
            res_status = STATUS_CHECKSUM;
         end else begin
            res_status = STATUS_OK;
         end
         in_frame_in = 1'b0;
         group_left_in = 8'd0;
         zero_pending_in = 1'b0;
         hold_in[0] = 8'd0;
         hold_in[1] = 8'd0;
         hold_count_in = 2'd0;
         sums_in.sum_low = SUM_INIT;
         sums_in.sum_high = SUM_INIT;
         count_in = '0;
         too_long_in = 1'b0;
      end else begin
         in_frame_in = 1'b1;
         if (group_left_ff == 8'd0) begin
            // Code byte: the previous group's implied zero turns out to be real.
            push_en = zero_pending_ff;
            push_data = 8'd0;
            group_left_in = req_link_byte - 8'd1;
            zero_pending_in = (req_link_byte != CODE_NO_ZERO);
         end else begin
            push_en = 1'b1;
            group_left_in = group_left_ff - 8'd1;
         end

         if (push_en) begin
            if (hold_count_ff == 2'd2) begin
               // The oldest held byte is no longer a checksum candidate.
               hold_in[0] = hold_ff[1];
               hold_in[1] = push_data;
               if (count_ff > count_type'(MAX_MSG)) begin
                  too_long_in = 1'b1;
               end else begin
                  emit_ok = 1'b1;
               end
            end else if (hold_count_ff == 2'd1) begin
               hold_in[1] = push_data;
               hold_count_in = 2'd2;
            end else begin
               hold_in[0] = push_data;
               hold_count_in = 2'd1;
            end
         end

         if (emit_ok) begin
            sums_in = sums_next;
            count_in = count_ff + count_type'(1);
            res_valid = 1'b1;
            res_byte = hold_ff[0];
            res_kind = (count_ff == '0) ? KIND_BUS_ID : KIND_MESSAGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         group_left_ff <= 8'd0;
         zero_pending_ff <= 1'b0;
         hold_ff[0] <= 8'd0;
         hold_ff[1] <= 8'd0;
         hold_count_ff <= 2'd0;
         sums_ff.sum_low <= SUM_INIT;
         sums_ff.sum_high <= SUM_INIT;
         count_ff <= '0;
         too_long_ff <= 1'b0;
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         group_left_ff <= group_left_in;
         zero_pending_ff <= zero_pending_in;
         hold_ff <= hold_in;
         hold_count_ff <= hold_count_in;
         sums_ff <= sums_in;
         count_ff <= count_in;
         too_long_ff <= too_long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_byte_ff <= res_byte;
         rsp_kind_ff <= res_kind;
         if (res_kind == KIND_STATUS) begin
            rsp_status_ff <= res_status;
            rsp_length_ff <= LEN_W'(msg_count);
         end else begin
            rsp_status_ff <= STATUS_OK;
            rsp_length_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_kind = rsp_kind_ff;
   assign rsp_frame_status = rsp_status_ff;
   assign rsp_msg_length = rsp_length_ff;

endmodule

// ----- rtl/cfd_fletcher.sv -----
module cfd_fletcher (
   input  cfd_pkg::sums_type sums,
   input  cfd_pkg::byte_type data,
   output cfd_pkg::sums_type sums_next
);
   import cfd_pkg::*;

   always_comb begin
      sums_next.sum_low = oc_add(sums.sum_low, data);
      sums_next.sum_high = oc_add(sums.sum_high, sums_next.sum_low);
   end

endmodule

// ----- tb/sv/tb_cobs_fletcher_frame_decoder.sv -----
module tb_cobs_fletcher_frame_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import cfd_pkg::*;

   localparam byte_type DELIMITER = 8'h00;
   localparam int CLOCK_HALF = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 16;

   typedef struct packed {
      byte_type    data;
      kind_type    kind;
      status_type  status;
      logic [10:0] length;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   byte_type    req_link_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   byte_type    rsp_out_byte;
   logic [1:0]  rsp_out_kind;
   logic [1:0]  rsp_frame_status;
   logic [10:0] rsp_msg_length;

   cobs_fletcher_frame_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_link_byte    (req_link_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_frame_status (rsp_frame_status),
      .rsp_msg_length   (rsp_msg_length)
   );

   // Expected decoder outputs, oldest first.
   frame_result_type decoded_results[$];
   frame_result_type next_result;

   // Frame under construction: raw bytes, then their COBS encoding.
   byte_type frame_bytes[$];
   byte_type link_bytes[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int sent_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   // Decoder state as the testbench tracks it.
   bit       rx_in_frame;
   byte_type rx_group_left;
   bit       rx_zero_due;
   byte_type rx_hold[2];
   int       rx_hold_count;
   byte_type rx_sum1;
   byte_type rx_sum2;
   int       rx_decoded;
   bit       rx_overflow;

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic byte_type ones_add(input byte_type a, input byte_type b);
      int total;
      total = int'(a) + int'(b);
      total = (total & 8'hFF) + (total >> 8);
      return total[7:0];
   endfunction

   function automatic void clear_frame_state();
      rx_in_frame = 1'b0;
      rx_group_left = 8'h00;
      rx_zero_due = 1'b0;
      rx_hold[0] = 8'h00;
      rx_hold[1] = 8'h00;
      rx_hold_count = 0;
      rx_sum1 = SUM_INIT;
      rx_sum2 = SUM_INIT;
      rx_decoded = 0;
      rx_overflow = 1'b0;
   endfunction

   // A decoded byte that is known not to be part of the checksum.
   function automatic void release_byte(input byte_type value);
      frame_result_type res;
      if (rx_decoded >= 1 && rx_decoded - 1 >= MAX_MSG) begin
         rx_overflow = 1'b1;
      end else begin
         rx_sum1 = ones_add(rx_sum1, value);
         rx_sum2 = ones_add(rx_sum2, rx_sum1);
         res.data = value;
         res.kind = (rx_decoded == 0) ? KIND_BUS_ID : KIND_MESSAGE;
         res.status = STATUS_OK;
         res.length = '0;
         decoded_results.push_back(res);
         rx_decoded++;
      end
   endfunction

   // The two newest decoded bytes stay held back as the checksum candidate.
   function automatic void take_decoded(input byte_type value);
      byte_type oldest;
      if (rx_hold_count >= 2) begin
         oldest = rx_hold[0];
         rx_hold[0] = rx_hold[1];
         rx_hold_count = 1;
         release_byte(oldest);
      end
      rx_hold[rx_hold_count] = value;
      rx_hold_count++;
   endfunction

   function automatic void close_frame();
      frame_result_type res;
      int msg;
      msg = (rx_decoded > 0) ? rx_decoded - 1 : 0;
      if (rx_group_left != 0 || rx_hold_count < 2 || rx_decoded == 0)
         res.status = STATUS_COBS;
      else if (rx_overflow)
         res.status = STATUS_TOO_LONG;
      else if (rx_hold[0] != rx_sum1 || rx_hold[1] != rx_sum2)
         res.status = STATUS_CHECKSUM;
      else
         res.status = STATUS_OK;
      res.data = 8'h00;
      res.kind = KIND_STATUS;
      res.length = msg[10:0];
      decoded_results.push_back(res);
   endfunction

   function automatic void predict_link_byte(input byte_type value);
      if (value == DELIMITER) begin
         if (rx_in_frame)
            close_frame();
         clear_frame_state();
      end else begin
         rx_in_frame = 1'b1;
         if (rx_group_left == 0) begin
            // A new code byte proves the previous group's zero was real data.
            if (rx_zero_due)
               take_decoded(8'h00);
            rx_group_left = value - 8'd1;
            rx_zero_due = (value != CODE_NO_ZERO);
         end else begin
            rx_group_left--;
            take_decoded(value);
         end
      end
   endfunction

   function automatic void compare_field(input string field, input logic [10:0] want,
                                         input logic [10:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_results.size() == 0) begin
            $error("unexpected transaction: kind %0d byte %0d", rsp_out_kind, rsp_out_byte);
            mismatch_count++;
         end else begin
            next_result = decoded_results.pop_front();
            compare_field("out_byte", 11'(next_result.data), 11'(rsp_out_byte));
            compare_field("out_kind", 11'(next_result.kind), 11'(rsp_out_kind));
            compare_field("frame_status", 11'(next_result.status), 11'(rsp_frame_status));
            compare_field("msg_length", next_result.length, rsp_msg_length);
         end
      end
   end

   task automatic send_link_byte(input byte_type value);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_link_byte <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_link_byte(value);
      sent_count++;
   endtask

   // Holds the sender off until every expected transaction has come out.
   task automatic drain();
      req_valid <= 1'b0;
      while (decoded_results.size() != 0)
         @(posedge clock);
   endtask

   function automatic byte_type random_data_byte(input int zero_pct);
      int r;
      r = $urandom_range(99);
      if (r < zero_pct)
         return 8'h00;
      else if (r < zero_pct + 8)
         return 8'hFF;
      return byte_type'($urandom_range(1, 254));
   endfunction

   function automatic void append_checksum();
      byte_type s1;
      byte_type s2;
      s1 = SUM_INIT;
      s2 = SUM_INIT;
      foreach (frame_bytes[i]) begin
         s1 = ones_add(s1, frame_bytes[i]);
         s2 = ones_add(s2, s1);
      end
      frame_bytes.push_back(s1);
      frame_bytes.push_back(s2);
   endfunction

   function automatic void build_frame(input int msg_len, input int zero_pct);
      frame_bytes.delete();
      for (int i = 0; i <= msg_len; i++)
         frame_bytes.push_back(random_data_byte(zero_pct));
      append_checksum();
   endfunction

   function automatic void encode_frame();
      int code_at;
      int group_code;
      link_bytes.delete();
      code_at = 0;
      group_code = 1;
      link_bytes.push_back(8'h00);
      foreach (frame_bytes[i]) begin
         if (frame_bytes[i] == 8'h00) begin
            link_bytes[code_at] = byte_type'(group_code);
            code_at = link_bytes.size();
            link_bytes.push_back(8'h00);
            group_code = 1;
         end else begin
            link_bytes.push_back(frame_bytes[i]);
            group_code++;
            if (group_code == 255) begin
               link_bytes[code_at] = byte_type'(group_code);
               code_at = link_bytes.size();
               link_bytes.push_back(8'h00);
               group_code = 1;
            end
         end
      end
      link_bytes[code_at] = byte_type'(group_code);
   endfunction

   task automatic send_encoded_frame();
      foreach (link_bytes[i])
         send_link_byte(link_bytes[i]);
      send_link_byte(DELIMITER);
   endtask

   task automatic test_directed();
      // No delimiter precedes the first frame; bus id 0x00, message byte 0xFF.
      frame_bytes.delete();
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'hFF);
      append_checksum();
      encode_frame();
      send_encoded_frame();
      // Back-to-back delimiters form empty frames and must stay silent.
      send_link_byte(DELIMITER);
      send_link_byte(DELIMITER);
      // Short frame with a single decoded byte.
      send_link_byte(8'h02);
      send_link_byte(8'h12);
      send_link_byte(DELIMITER);
      // A lone code byte decodes to nothing.
      send_link_byte(8'h01);
      send_link_byte(DELIMITER);
      // Group cut off by the delimiter.
      send_link_byte(8'h05);
      send_link_byte(8'h11);
      send_link_byte(8'h22);
      send_link_byte(DELIMITER);
      // Corrupted checksum: the message still comes out.
      frame_bytes.delete();
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'h01);
      frame_bytes.push_back(8'h80);
      append_checksum();
      frame_bytes[3] = frame_bytes[3] ^ 8'h01;
      encode_frame();
      send_encoded_frame();
   endtask

   task automatic test_long_frames();
      // One byte over the largest message: all but the last message byte come out.
      build_frame(MAX_MSG + 1, 1);
      encode_frame();
      send_encoded_frame();
   endtask

   task automatic test_random(input int n_items);
      int stop_at;
      int pick;
      int count;
      int msg_len;
      stop_at = sent_count + n_items;
      while (sent_count < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            count = $urandom_range(0, 6);
            repeat (count)
               send_link_byte(byte_type'($urandom_range(0, 255)));
            send_link_byte(DELIMITER);
         end else begin
            count = $urandom_range(99);
            if (count < 88)
               msg_len = $urandom_range(0, 12);
            else if (count < 98)
               msg_len = $urandom_range(13, 60);
            else
               msg_len = $urandom_range(200, 300);
            build_frame(msg_len, 20);
            if (pick < 16) begin
               count = frame_bytes.size() - 1 - $urandom_range(0, 1);
               frame_bytes[count] = frame_bytes[count] ^ byte_type'($urandom_range(1, 255));
            end
            encode_frame();
            if (pick >= 16 && pick < 24) begin
               count = $urandom_range(1, 3);
               while (count > 0 && link_bytes.size() > 0) begin
                  void'(link_bytes.pop_back());
                  count--;
               end
            end else if (pick >= 24 && pick < 31) begin
               count = $urandom_range(0, link_bytes.size() - 1);
               link_bytes[count] = byte_type'($urandom_range(0, 255));
            end
            send_encoded_frame();
         end
      end
   endtask

   initial begin
      clear_frame_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      drain();

      send_idle_pct = 8;
      stall_pct = 8;
      test_long_frames();
      drain();

      send_idle_pct = 0;
      stall_pct = 0;
      test_random(95);
      drain();

      send_idle_pct = 77;
      stall_pct = 0;
      test_random(95);
      drain();

      send_idle_pct = 0;
      stall_pct = 77;
      test_random(95);
      drain();

      send_idle_pct = 8;
      stall_pct = 8;
      test_random(95);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/cfd_pkg.sv
rtl/cfd_fletcher.sv
rtl/cobs_fletcher_frame_decoder.sv
tb/sv/tb_cobs_fletcher_frame_decoder.sv
